/* hw/rtl/pnsf_pkg.sv */
`default_nettype none

package pnsf_pkg;

	// sample, state and coefficient formats
	localparam int SAMPLE_BITS     = 16;
	localparam int STATE_FRAC_BITS = 24;
	localparam int COEF_FRAC       = 24;
	localparam int STATE_W         = 32;
	localparam int COEF_W          = COEF_FRAC + 1;
	localparam int SUM_W           = STATE_W + 3;
	localparam int ACC_W           = STATE_W + 4;
	localparam int PROD_W          = SUM_W + COEF_W;
	localparam int W_SHIFT         = COEF_FRAC + SAMPLE_BITS - 1 - STATE_FRAC_BITS;
	localparam int O_SHIFT         = COEF_FRAC + STATE_FRAC_BITS - SAMPLE_BITS + 1;
	localparam int Y_W             = PROD_W - O_SHIFT;

	// six sections plus the delayed term
	localparam int SEC_N     = 7;
	localparam int DELAY_IDX = SEC_N - 1;

	// microprogram layout
	localparam int UCODE_LEN = 17;
	localparam int STEP_W    = $clog2(UCODE_LEN);

	typedef logic [STEP_W-1:0]        step_t;
	typedef logic [$clog2(SEC_N)-1:0] sec_idx_t;

	// multiplier operand a source
	typedef enum logic [1:0] {
		A_SEC,
		A_W,
		A_SUM
	} a_sel_t;

	// coefficient rom address
	typedef enum logic [3:0] {
		C_P0, C_P1, C_P2, C_P3, C_P4, C_P5,
		C_G0, C_G1, C_G2, C_G3, C_G4, C_G5,
		C_DIRECT, C_DELAY, C_OUT
	} coef_t;

	// what the step does with the product of the previous step
	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_FB,
		ACC_SEC_ADD,
		ACC_SEC_SUB,
		ACC_DIRECT,
		ACC_DELAY,
		ACC_OUT
	} acc_op_t;

	// sequencing of the step counter
	typedef enum logic [1:0] {
		J_NEXT,
		J_WAIT_IN,
		J_WAIT_OUT
	} jmp_t;

	typedef struct packed {
		logic     take;
		logic     mul_en;
		a_sel_t   a_sel;
		sec_idx_t rd_idx;
		coef_t    coef;
		acc_op_t  acc;
		sec_idx_t wr_idx;
		jmp_t     jmp;
	} ucw_t;

	localparam step_t STEP_WAIT = step_t'(0);
	localparam step_t STEP_OUT  = step_t'(UCODE_LEN - 1);

	// coefficients, round(value * 2^24)
	function automatic logic signed [COEF_W-1:0] coef_value(input coef_t c);
		logic signed [COEF_W-1:0] v;
		unique case (c)
			C_P0:     v = 25'sd16758090;
			C_P1:     v = 25'sd16665144;
			C_P2:     v = 25'sd16257122;
			C_P3:     v = 25'sd14537458;
			C_P4:     v = 25'sd9227469;
			C_P5:     v = -25'sd12777528;
			C_G0:     v = 25'sd931436;
			C_G1:     v = 25'sd1259565;
			C_G2:     v = 25'sd2581208;
			C_G3:     v = 25'sd5209084;
			C_G4:     v = 25'sd8941454;
			C_G5:     v = 25'sd283501;
			C_DIRECT: v = 25'sd8995943;
			C_DELAY:  v = 25'sd1944916;
			C_OUT:    v = 25'sd1845494;
			default:  v = '0;
		endcase
		return v;
	endfunction

	function automatic ucw_t uw(input logic take, input logic mul_en, input a_sel_t a,
			input sec_idx_t rd, input coef_t c, input acc_op_t acc,
			input sec_idx_t wr, input jmp_t j);
		ucw_t cw;
		cw.take   = take;
		cw.mul_en = mul_en;
		cw.a_sel  = a;
		cw.rd_idx = rd;
		cw.coef   = c;
		cw.acc    = acc;
		cw.wr_idx = wr;
		cw.jmp    = j;
		return cw;
	endfunction

	// microprogram: multiply in step n, consume the product in step n+1
	function automatic ucw_t ucode(input step_t step);
		ucw_t cw;
		unique case (step)
			5'd0:  cw = uw(1'b1, 1'b0, A_SEC, 3'd0, C_P0,     ACC_NONE,    3'd0, J_WAIT_IN);
			5'd1:  cw = uw(1'b0, 1'b1, A_SEC, 3'd0, C_P0,     ACC_NONE,    3'd0, J_NEXT);
			5'd2:  cw = uw(1'b0, 1'b1, A_W,   3'd0, C_G0,     ACC_FB,      3'd0, J_NEXT);
			5'd3:  cw = uw(1'b0, 1'b1, A_SEC, 3'd1, C_P1,     ACC_SEC_ADD, 3'd0, J_NEXT);
			5'd4:  cw = uw(1'b0, 1'b1, A_W,   3'd0, C_G1,     ACC_FB,      3'd0, J_NEXT);
			5'd5:  cw = uw(1'b0, 1'b1, A_SEC, 3'd2, C_P2,     ACC_SEC_ADD, 3'd1, J_NEXT);
			5'd6:  cw = uw(1'b0, 1'b1, A_W,   3'd0, C_G2,     ACC_FB,      3'd0, J_NEXT);
			5'd7:  cw = uw(1'b0, 1'b1, A_SEC, 3'd3, C_P3,     ACC_SEC_ADD, 3'd2, J_NEXT);
			5'd8:  cw = uw(1'b0, 1'b1, A_W,   3'd0, C_G3,     ACC_FB,      3'd0, J_NEXT);
			5'd9:  cw = uw(1'b0, 1'b1, A_SEC, 3'd4, C_P4,     ACC_SEC_ADD, 3'd3, J_NEXT);
			5'd10: cw = uw(1'b0, 1'b1, A_W,   3'd0, C_G4,     ACC_FB,      3'd0, J_NEXT);
			5'd11: cw = uw(1'b0, 1'b1, A_SEC, 3'd5, C_P5,     ACC_SEC_ADD, 3'd4, J_NEXT);
			5'd12: cw = uw(1'b0, 1'b1, A_W,   3'd0, C_G5,     ACC_FB,      3'd0, J_NEXT);
			5'd13: cw = uw(1'b0, 1'b1, A_W,   3'd0, C_DIRECT, ACC_SEC_SUB, 3'd5, J_NEXT);
			5'd14: cw = uw(1'b0, 1'b1, A_W,   3'd0, C_DELAY,  ACC_DIRECT,  3'd0, J_NEXT);
			5'd15: cw = uw(1'b0, 1'b1, A_SUM, 3'd0, C_OUT,    ACC_DELAY,   3'd6, J_NEXT);
			5'd16: cw = uw(1'b0, 1'b0, A_SEC, 3'd0, C_OUT,    ACC_OUT,     3'd0, J_WAIT_OUT);
			default: cw = uw(1'b0, 1'b0, A_SEC, 3'd0, C_P0,   ACC_NONE,    3'd0, J_WAIT_OUT);
		endcase
		return cw;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/pink_noise_shaping_filter_core.sv */
// a result is loaded into the output register in the last step of its input's program
// a new sample is taken only once the previous one's program has finished; the 17-step
// microprogram runs every product through one shared 35x25 multiplier
// the next input is taken while a finished result still waits in the output register
// reset: arst_n clears the sequencer, the output valid flag and all section state
`default_nettype none

module pink_noise_shaping_filter_core (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     in_valid,
	output logic                                    in_ready,
	input  wire  signed [pnsf_pkg::SAMPLE_BITS-1:0] white_sample,
	output logic                                    out_valid,
	input  wire                                     out_ready,
	output logic signed [pnsf_pkg::SAMPLE_BITS-1:0] pink_sample,
	output logic                                    clipped
);

	localparam int STATE_W = pnsf_pkg::STATE_W;
	localparam int SUM_W   = pnsf_pkg::SUM_W;
	localparam int ACC_W   = pnsf_pkg::ACC_W;
	localparam int PROD_W  = pnsf_pkg::PROD_W;
	localparam int Y_W     = pnsf_pkg::Y_W;
	localparam int S_BITS  = pnsf_pkg::SAMPLE_BITS;

	localparam logic signed [PROD_W-1:0] HALF_FB  = PROD_W'(1) << (pnsf_pkg::COEF_FRAC - 1);
	localparam logic signed [PROD_W-1:0] HALF_W   = PROD_W'(1) << (pnsf_pkg::W_SHIFT - 1);
	localparam logic signed [PROD_W-1:0] HALF_OUT = PROD_W'(1) << (pnsf_pkg::O_SHIFT - 1);
	localparam logic signed [ACC_W-1:0]  ST_MAX   =
		{{(ACC_W - STATE_W + 1){1'b0}}, {(STATE_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0]  ST_MIN   = ~ST_MAX;
	localparam logic signed [Y_W-1:0]    Y_MAX    =
		{{(Y_W - S_BITS + 1){1'b0}}, {(S_BITS - 1){1'b1}}};
	localparam logic signed [Y_W-1:0]    Y_MIN    = ~Y_MAX;

	pnsf_pkg::step_t step_q;
	pnsf_pkg::step_t step_d;
	pnsf_pkg::ucw_t  cw;

	logic signed [S_BITS-1:0]  w_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   fb_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [STATE_W-1:0] sec_q [pnsf_pkg::SEC_N];

	logic signed [SUM_W-1:0]   a_op;
	logic signed [pnsf_pkg::COEF_W-1:0] b_op;
	logic signed [PROD_W-1:0]  prod_d;
	logic signed [PROD_W-1:0]  fb_full;
	logic signed [PROD_W-1:0]  ff_full;
	logic signed [PROD_W-1:0]  y_full;
	logic signed [ACC_W-1:0]   ff_rnd;
	logic signed [ACC_W-1:0]   sec_sum;
	logic signed [STATE_W-1:0] sec_sat;
	logic signed [STATE_W-1:0] dly_sat;
	logic signed [Y_W-1:0]     y_val;

	logic                      out_valid_q;
	logic signed [S_BITS-1:0]  pink_q;
	logic                      clip_q;
	logic                      out_free;
	logic                      in_beat;

	function automatic logic signed [STATE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [STATE_W-1:0] r;
		if (v > ST_MAX) begin
			r = ST_MAX[STATE_W-1:0];
		end else if (v < ST_MIN) begin
			r = ST_MIN[STATE_W-1:0];
		end else begin
			r = v[STATE_W-1:0];
		end
		return r;
	endfunction

	// control word of the current step
	always_comb begin
		cw       = pnsf_pkg::ucode(step_q);
		in_ready = cw.take;
		in_beat  = in_valid && cw.take;
		out_free = !out_valid_q || out_ready;
	end

	// step counter with conditional holds
	always_comb begin
		step_d = step_q + pnsf_pkg::step_t'(1);
		unique case (cw.jmp)
			pnsf_pkg::J_NEXT: begin
				step_d = step_q + pnsf_pkg::step_t'(1);
			end
			pnsf_pkg::J_WAIT_IN: begin
				step_d = in_valid ? step_q + pnsf_pkg::step_t'(1) : step_q;
			end
			pnsf_pkg::J_WAIT_OUT: begin
				step_d = out_free ? pnsf_pkg::STEP_WAIT : step_q;
			end
			default: begin
				step_d = pnsf_pkg::STEP_WAIT;
			end
		endcase
	end

	// shared multiplier operands
	always_comb begin
		unique case (cw.a_sel)
			pnsf_pkg::A_SEC: a_op = SUM_W'(sec_q[cw.rd_idx]);
			pnsf_pkg::A_W:   a_op = SUM_W'(w_q);
			pnsf_pkg::A_SUM: a_op = sum_q;
			default:         a_op = '0;
		endcase
		b_op   = pnsf_pkg::coef_value(cw.coef);
		prod_d = PROD_W'(a_op) * PROD_W'(b_op);
	end

	// round half up and saturate the registered product
	always_comb begin
		fb_full = (prod_q + HALF_FB) >>> pnsf_pkg::COEF_FRAC;
		ff_full = (prod_q + HALF_W) >>> pnsf_pkg::W_SHIFT;
		y_full  = (prod_q + HALF_OUT) >>> pnsf_pkg::O_SHIFT;
		ff_rnd  = ff_full[ACC_W-1:0];
		sec_sum = (cw.acc == pnsf_pkg::ACC_SEC_SUB) ? fb_q - ff_rnd : fb_q + ff_rnd;
		sec_sat = sat32(sec_sum);
		dly_sat = sat32(ff_rnd);
		y_val   = y_full[Y_W-1:0];
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= pnsf_pkg::STEP_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

	// section and delayed-term state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pnsf_pkg::SEC_N; i++) begin
				sec_q[i] <= '0;
			end
		end else begin
			case (cw.acc) inside
				pnsf_pkg::ACC_SEC_ADD, pnsf_pkg::ACC_SEC_SUB: begin
					sec_q[cw.wr_idx] <= sec_sat;
				end
				pnsf_pkg::ACC_DELAY: begin
					sec_q[pnsf_pkg::DELAY_IDX] <= dly_sat;
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			w_q <= white_sample;
		end
		if (cw.mul_en) begin
			prod_q <= prod_d;
		end
		case (cw.acc) inside
			pnsf_pkg::ACC_FB: begin
				fb_q <= fb_full[ACC_W-1:0];
			end
			pnsf_pkg::ACC_SEC_ADD, pnsf_pkg::ACC_SEC_SUB: begin
				sum_q <= sum_q + SUM_W'(sec_sat);
			end
			pnsf_pkg::ACC_DIRECT: begin
				sum_q <= sum_q + ff_rnd[SUM_W-1:0] + SUM_W'(sec_q[pnsf_pkg::DELAY_IDX]);
			end
			default: begin
				if (in_beat) begin
					sum_q <= '0;
				end
			end
		endcase
	end

	// output register, loaded in the last step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.acc == pnsf_pkg::ACC_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.acc == pnsf_pkg::ACC_OUT && out_free) begin
			if (y_val > Y_MAX) begin
				pink_q <= Y_MAX[S_BITS-1:0];
				clip_q <= 1'b1;
			end else if (y_val < Y_MIN) begin
				pink_q <= Y_MIN[S_BITS-1:0];
				clip_q <= 1'b1;
			end else begin
				pink_q <= y_val[S_BITS-1:0];
				clip_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign pink_sample = pink_q;
	assign clipped     = clip_q;

	// checks
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= pnsf_pkg::STEP_OUT)
		else $error("step counter beyond microprogram");

	a_beat_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> step_q == pnsf_pkg::step_t'(1))
		else $error("input beat did not start the program");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(step_q) == pnsf_pkg::STEP_OUT)
		else $error("result raised outside the output step");

	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && clip_q) |->
			(pink_q == Y_MAX[S_BITS-1:0] || pink_q == Y_MIN[S_BITS-1:0]))
		else $error("clipped result not at a rail");

endmodule

`default_nettype wire
